[rtl/uvdt_pkg.sv]
// Package for the vertex dedup table: shared types and constants.
// No dependencies.
`default_nettype none
package uvdt_pkg;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;
  localparam int WORD_W = 32;
  localparam int NWORDS = 9;
  localparam int ATTR_W = NWORDS * WORD_W;

  typedef logic [ATTR_W-1:0] attr_t;

  typedef struct packed {
    logic [IDX_W-1:0] orig_index;
    attr_t            attr;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_OUT
  } walk_state_t;
endpackage
`default_nettype wire

[rtl/uvdt_if.sv]
// Valid/ready channel interfaces for corner input and result output.
// Depends on uvdt_pkg.
`default_nettype none
interface uvdt_in_if;
  logic                      valid;
  logic                      ready;
  logic [uvdt_pkg::IDX_W-1:0] orig_index;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] norm_x;
  logic [31:0] norm_y;
  logic [31:0] norm_z;
  logic [31:0] tex_u;
  logic [31:0] tex_v;
  logic [31:0] colour_word;
  modport source (output valid, orig_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, colour_word, input ready);
  modport sink (input valid, orig_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                tex_u, tex_v, colour_word, output ready);
endinterface

interface uvdt_out_if;
  logic                      valid;
  logic                      ready;
  logic [uvdt_pkg::IDX_W-1:0] vertex_index;
  logic                      is_new;
  logic                      error_flag;
  modport source (output valid, vertex_index, is_new, error_flag, input ready);
  modport sink (input valid, vertex_index, is_new, error_flag, output ready);
endinterface
`default_nettype wire

[rtl/uvdt_front.sv]
// Front end: accepts corner words and queues them in a two-entry FIFO.
// Depends on uvdt_pkg.
`default_nettype none
module uvdt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire uvdt_pkg::req_t in_req,
  output logic               q_valid,
  input  wire logic          q_ready,
  output uvdt_pkg::req_t     q_req
);
  uvdt_pkg::req_t mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_req    = mem[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_req;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/uvdt_back.sv]
// Back end: walks the entry chain in the table memories and emits one result.
// Depends on uvdt_pkg.
`default_nettype none
module uvdt_back #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [uvdt_pkg::CNT_W-1:0] cfg_data,
  input  wire logic                      q_valid,
  output logic                           q_ready,
  input  wire uvdt_pkg::req_t             q_req,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [uvdt_pkg::IDX_W-1:0]      out_index,
  output logic                           out_is_new,
  output logic                           out_error
);
  localparam int CAP = (TABLE_DEPTH < 4096) ? TABLE_DEPTH : 4096;
  localparam int AW = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [uvdt_pkg::CNT_W-1:0] CAP_C = uvdt_pkg::CNT_W'(CAP);

  // Valid marks live in memory with a clearing pass after reset or config.
  logic                       vmem [CAP];
  logic [uvdt_pkg::IDX_W-1:0] nmem [CAP];
  uvdt_pkg::attr_t            amem [CAP];

  uvdt_pkg::walk_state_t state, state_next;
  logic [uvdt_pkg::CNT_W-1:0] pos_count;
  logic [uvdt_pkg::CNT_W-1:0] alloc_count;
  logic [uvdt_pkg::CNT_W-1:0] clr_ptr;
  uvdt_pkg::req_t             req;
  logic [uvdt_pkg::CNT_W-1:0] cur;
  logic                       at_home;
  logic                       home_err;
  logic                       rd_v;
  logic [uvdt_pkg::IDX_W-1:0] rd_n;
  uvdt_pkg::attr_t            rd_a;
  logic [uvdt_pkg::CNT_W-1:0] cfg_sat;

  logic                       wr_en, link_en;
  logic [AW-1:0]              wr_addr, link_addr;
  logic [uvdt_pkg::IDX_W-1:0] link_val;
  logic [uvdt_pkg::IDX_W-1:0] res_idx;
  logic                       res_new, res_err;

  // Tail link of an append; written in the first output cycle since the
  // new entry's own link clear takes the write port in the check cycle.
  logic                       tail_pend;
  logic [AW-1:0]              tail_addr;
  logic [uvdt_pkg::IDX_W-1:0] tail_val;

  assign cfg_sat = (cfg_data > CAP_C) ? CAP_C : cfg_data;
  assign q_ready = (state == uvdt_pkg::ST_IDLE) && !cfg_we;
  // Range check applies to the home slot only; appended entries sit above it.
  assign home_err = at_home && (cur >= pos_count);

  always_comb begin
    state_next = state;
    wr_en = 1'b0;
    link_en = 1'b0;
    wr_addr = cur[AW-1:0];
    link_addr = cur[AW-1:0];
    link_val = alloc_count[uvdt_pkg::IDX_W-1:0];
    res_idx = '0;
    res_new = 1'b0;
    res_err = 1'b0;
    unique case (state)
      uvdt_pkg::ST_IDLE: begin
        if (q_valid && q_ready) state_next = uvdt_pkg::ST_READ;
      end
      uvdt_pkg::ST_READ: begin
        if (home_err) begin
          res_err = 1'b1;
          state_next = uvdt_pkg::ST_OUT;
        end else begin
          state_next = uvdt_pkg::ST_CHECK;
        end
      end
      uvdt_pkg::ST_CHECK: begin
        state_next = uvdt_pkg::ST_OUT;
        priority if (!rd_v) begin
          wr_en = 1'b1;
          res_idx = cur[uvdt_pkg::IDX_W-1:0];
          res_new = 1'b1;
        end else if (rd_a == req.attr) begin
          res_idx = cur[uvdt_pkg::IDX_W-1:0];
        end else if (rd_n != '0) begin
          state_next = uvdt_pkg::ST_READ;
        end else if (alloc_count >= CAP_C) begin
          res_err = 1'b1;
        end else begin
          wr_en = 1'b1;
          wr_addr = alloc_count[AW-1:0];
          link_en = 1'b1;
          res_idx = alloc_count[uvdt_pkg::IDX_W-1:0];
          res_new = 1'b1;
        end
      end
      uvdt_pkg::ST_CLEAR: begin
        if (clr_ptr == CAP_C - 1'b1) state_next = uvdt_pkg::ST_IDLE;
      end
      uvdt_pkg::ST_OUT: begin
        if (out_ready) state_next = uvdt_pkg::ST_IDLE;
      end
      default: state_next = uvdt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uvdt_pkg::ST_CLEAR;
      pos_count <= '0;
      alloc_count <= '0;
      clr_ptr <= '0;
      out_valid <= 1'b0;
    end else if (cfg_we) begin
      pos_count <= cfg_sat;
      alloc_count <= cfg_sat;
      clr_ptr <= '0;
      state <= uvdt_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == uvdt_pkg::ST_CLEAR) clr_ptr <= clr_ptr + 1'b1;
      if (link_en) alloc_count <= alloc_count + 1'b1;
      if ((state == uvdt_pkg::ST_READ && home_err) ||
          (state == uvdt_pkg::ST_CHECK && state_next == uvdt_pkg::ST_OUT))
        out_valid <= 1'b1;
      else if (state == uvdt_pkg::ST_OUT && out_ready)
        out_valid <= 1'b0;
    end
  end

  // Payload and walk pointer.
  always_ff @(posedge clk) begin
    if (state == uvdt_pkg::ST_IDLE && q_valid && q_ready) begin
      req <= q_req;
      cur <= {1'b0, q_req.orig_index};
      at_home <= 1'b1;
    end else if (state == uvdt_pkg::ST_CHECK && state_next == uvdt_pkg::ST_READ) begin
      cur <= {1'b0, rd_n};
      at_home <= 1'b0;
    end
    if ((state == uvdt_pkg::ST_READ && home_err) ||
        (state == uvdt_pkg::ST_CHECK && state_next == uvdt_pkg::ST_OUT)) begin
      out_index <= res_idx;
      out_is_new <= res_new;
      out_error <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      tail_pend <= 1'b0;
    end else if (state == uvdt_pkg::ST_CHECK) begin
      tail_pend <= link_en;
    end else if (state == uvdt_pkg::ST_OUT) begin
      tail_pend <= 1'b0;
    end
    if (link_en) begin
      tail_addr <= link_addr;
      tail_val <= link_val;
    end
  end

  // Table memories: registered reads, one write port each.
  always_ff @(posedge clk) begin
    if (state == uvdt_pkg::ST_CLEAR) begin
      vmem[clr_ptr[AW-1:0]] <= 1'b0;
    end else if (wr_en) begin
      vmem[wr_addr] <= 1'b1;
    end
    rd_v <= vmem[cur[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) amem[wr_addr] <= req.attr;
    rd_a <= amem[cur[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == uvdt_pkg::ST_OUT && tail_pend) nmem[tail_addr] <= tail_val;
    else if (wr_en) nmem[wr_addr] <= '0;
    rd_n <= nmem[cur[AW-1:0]];
  end
endmodule
`default_nettype wire

[rtl/unique_vertex_dedup_table.sv]
// Vertex dedup table: each corner gets a unique vertex index via chained table.
// Each corner passes READ, CHECK and OUT, with READ and CHECK again per hop (READ, OUT if out of range).
// The back end takes a new corner only after the last result is taken; the queue holds two.
// Reset (synchronous, rst high) and each position_count write start a clearing pass
// over min(TABLE_DEPTH,4096) entries; the back end takes no corners then, the queue two.
// Depends on uvdt_pkg, uvdt_if, uvdt_front, uvdt_back.
`default_nettype none
module unique_vertex_dedup_table #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [uvdt_pkg::CNT_W-1:0] cfg_data,
  uvdt_in_if.sink                        corner,
  uvdt_out_if.source                     result
);
  uvdt_pkg::req_t in_req;
  uvdt_pkg::req_t q_req;
  logic           q_valid;
  logic           q_ready;

  // Pack the nine attribute words into one queue word.
  assign in_req.orig_index = corner.orig_index;
  assign in_req.attr = {corner.pos_x, corner.pos_y, corner.pos_z,
                        corner.norm_x, corner.norm_y, corner.norm_z,
                        corner.tex_u, corner.tex_v, corner.colour_word};

  uvdt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (corner.valid),
    .in_ready (corner.ready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req)
  );

  uvdt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_index  (result.vertex_index),
    .out_is_new (result.is_new),
    .out_error  (result.error_flag)
  );
endmodule
`default_nettype wire

[rtl/uvdt_checker.sv]
// Port-level checker for the vertex dedup table, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none
module uvdt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [11:0] res_index,
  input wire logic        res_new,
  input wire logic        res_err
);
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_err |-> res_index == 12'd0 && !res_new)
    else $error("error word carries nonzero fields");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_index))
    else $error("stalled word changed");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> !res_valid)
    else $error("word repeated");
endmodule

bind unique_vertex_dedup_table uvdt_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_index (result.vertex_index),
  .res_new   (result.is_new),
  .res_err   (result.error_flag)
);
`default_nettype wire

[test/unique_vertex_dedup_table_tb.sv]
// Self-checking bench for unique_vertex_dedup_table: directed rows, then random corners.
// Depends on uvdt_pkg, uvdt_if and the table RTL. A local model of the chained table
// predicts each result word.
`default_nettype none
module unique_vertex_dedup_table_tb;

  localparam int CAP        = 4096;   // usable depth: min(TABLE_DEPTH, 2**IDX_W)
  localparam int IDLE_LIMIT = 40000;  // clearing pass covers all 4096 slots; each chain hop adds a READ and a CHECK
  localparam int KEEP_CFG   = -1;     // directed row leaves position_count alone

  typedef struct packed {
    logic [uvdt_pkg::IDX_W-1:0] vertex_index;
    logic                       is_new;
    logic                       error_flag;
  } vtx_res_t;

  typedef struct {
    int                         cfg;
    logic [uvdt_pkg::IDX_W-1:0] orig;
    uvdt_pkg::attr_t            attr;
    bit                         typed;
    vtx_res_t                   res;
  } corner_row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [uvdt_pkg::CNT_W-1:0] cfg_data = '0;

  uvdt_in_if  corner();
  uvdt_out_if result();

  unique_vertex_dedup_table uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .corner(corner.sink), .result(result.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the table: valid marks, links, stored words, allocation pointer.
  bit                         tbl_valid [CAP];
  logic [uvdt_pkg::IDX_W-1:0] tbl_next  [CAP];
  uvdt_pkg::attr_t            tbl_attr  [CAP];
  int               pos_count;
  int               alloc_ptr;

  vtx_res_t        pending_q[$];   // expected result words, oldest first
  corner_row_t     rows[$];
  uvdt_pkg::attr_t pool[6];        // per-phase attribute pool so matches happen
  int          fails;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_go;        // toggled by main to request a receiver hold-off
  int          hold_len;

  // Walk the chain from the home slot; fill, match, append or refuse.
  function automatic vtx_res_t dedup_lookup(logic [uvdt_pkg::IDX_W-1:0] orig,
                                            uvdt_pkg::attr_t a);
    vtx_res_t r;
    int cur;
    r = '{vertex_index: '0, is_new: 1'b0, error_flag: 1'b1};
    if (orig >= pos_count) return r;
    cur = orig;
    for (int s = 0; s <= CAP; s++) begin
      if (!tbl_valid[cur]) begin
        tbl_valid[cur] = 1'b1; tbl_attr[cur] = a; tbl_next[cur] = '0;
        r = '{vertex_index: cur[uvdt_pkg::IDX_W-1:0], is_new: 1'b1, error_flag: 1'b0};
        return r;
      end
      if (tbl_attr[cur] == a) begin
        r = '{vertex_index: cur[uvdt_pkg::IDX_W-1:0], is_new: 1'b0, error_flag: 1'b0};
        return r;
      end
      if (tbl_next[cur] == '0) begin
        if (alloc_ptr >= CAP) return r;   // table full
        tbl_valid[alloc_ptr] = 1'b1; tbl_attr[alloc_ptr] = a;
        tbl_next[alloc_ptr] = '0;
        tbl_next[cur] = alloc_ptr[uvdt_pkg::IDX_W-1:0];
        r = '{vertex_index: alloc_ptr[uvdt_pkg::IDX_W-1:0], is_new: 1'b1,
              error_flag: 1'b0};
        alloc_ptr++;
        return r;
      end
      cur = tbl_next[cur];
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    fails++;
    $display("ERR t=%0t %s got %0d want %0d", $time, what, got, want);
  endtask

  // Block must be idle: all words back, then a short margin before the write.
  task automatic set_count(int v);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v[uvdt_pkg::CNT_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    pos_count = (v[uvdt_pkg::CNT_W-1:0] > CAP) ? CAP : v[uvdt_pkg::CNT_W-1:0];
    alloc_ptr = pos_count;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
  endtask

  // Offer one corner; valid stays high afterwards unless the next call idles.
  task automatic send_corner(logic [uvdt_pkg::IDX_W-1:0] orig, uvdt_pkg::attr_t a,
                             bit typed, vtx_res_t fixed);
    vtx_res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      corner.valid <= 1'b0;
      @(posedge clk);
    end
    corner.valid <= 1'b1;
    corner.orig_index <= orig;
    {corner.pos_x, corner.pos_y, corner.pos_z, corner.norm_x, corner.norm_y,
     corner.norm_z, corner.tex_u, corner.tex_v, corner.colour_word} <= a;
    do @(posedge clk); while (!corner.ready);
    r = dedup_lookup(orig, a);
    pending_q.insert(pending_q.size(), typed ? fixed : r);
  endtask

  function automatic uvdt_pkg::attr_t rand_attr();
    uvdt_pkg::attr_t a;
    for (int k = 0; k < uvdt_pkg::NWORDS; k++)
      a[k*uvdt_pkg::WORD_W +: uvdt_pkg::WORD_W] = $urandom;
    return a;
  endfunction

  task automatic add_row(int cfg, int orig, uvdt_pkg::attr_t a, bit typed, int idx,
                         bit nw, bit err);
    corner_row_t row;
    row.cfg = cfg; row.orig = orig[uvdt_pkg::IDX_W-1:0]; row.attr = a; row.typed = typed;
    row.res = '{vertex_index: idx[uvdt_pkg::IDX_W-1:0], is_new: nw, error_flag: err};
    rows.insert(rows.size(), row);
  endtask

  // Receiver: random stall, plus a long hold-off counted here on request.
  always @(posedge clk) begin
    vtx_res_t want;
    bit       hold_seen;
    if (rst) begin
      result.ready <= 1'b0;
      hold_len     <= 0;
      hold_seen     = hold_go;
    end else begin
      if (result.valid && result.ready) begin
        if (pending_q.size() == 0) begin
          report("unexpected word, index", result.vertex_index, -1);
        end else begin
          want = pending_q.pop_front();
          if (result.vertex_index !== want.vertex_index)
            report("vertex_index", result.vertex_index, want.vertex_index);
          if (result.is_new !== want.is_new)
            report("is_new", result.is_new, want.is_new);
          if (result.error_flag !== want.error_flag)
            report("error_flag", result.error_flag, want.error_flag);
        end
      end
      if (hold_go != hold_seen) begin
        hold_seen     = hold_go;
        hold_len     <= 400;
        result.ready <= 1'b0;
      end else if (hold_len > 0) begin
        hold_len     <= hold_len - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((corner.valid && corner.ready) || (result.valid && result.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    uvdt_pkg::attr_t a_a, a_b, a_c, a_d, ones, pz, nz, qnan;
    int    counts[7];
    int    idles[7];
    int    stalls[7];
    logic [uvdt_pkg::IDX_W-1:0] orig;
    uvdt_pkg::attr_t a;

    fails = 0; idle_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    hold_go = 1'b0;
    corner.valid = 1'b0; corner.orig_index = '0;
    {corner.pos_x, corner.pos_y, corner.pos_z, corner.norm_x, corner.norm_y,
     corner.norm_z, corner.tex_u, corner.tex_v, corner.colour_word} = '0;
    pos_count = 0; alloc_ptr = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    a_a  = {9{32'h3F80_0000}};
    a_b  = {9{32'h4000_0000}};
    a_c  = {9{32'hBF80_0000}};
    a_d  = {9{32'h1234_5678}};
    ones = {9{32'hFFFF_FFFF}};
    pz   = '0;
    nz   = {32'h8000_0000, {8{32'h0}}};     // -0 in pos_x only
    qnan = {9{32'h7FC0_0001}};

    // Directed: after reset nothing is in range.
    add_row(KEEP_CFG, 0,    a_a,  1, 0, 0, 1);
    add_row(KEEP_CFG, 4095, ones, 1, 0, 0, 1);
    // Small mesh: fill, match, append, out of range, signed zero, NaN pattern.
    add_row(4,        0, a_a,  1, 0, 1, 0);
    add_row(KEEP_CFG, 0, a_a,  1, 0, 0, 0);
    add_row(KEEP_CFG, 0, a_b,  1, 4, 1, 0);
    add_row(KEEP_CFG, 0, a_b,  1, 4, 0, 0);
    add_row(KEEP_CFG, 3, ones, 1, 3, 1, 0);
    add_row(KEEP_CFG, 4, a_a,  1, 0, 0, 1);
    add_row(KEEP_CFG, 1, pz,   1, 1, 1, 0);
    add_row(KEEP_CFG, 1, nz,   1, 5, 1, 0);
    add_row(KEEP_CFG, 2, qnan, 1, 2, 1, 0);
    add_row(KEEP_CFG, 2, qnan, 1, 2, 0, 0);
    add_row(KEEP_CFG, 0, a_c,  0, 0, 0, 0);
    add_row(KEEP_CFG, 0, a_a,  0, 0, 0, 0);
    // Near-full table: two spare slots, then refusal.
    add_row(4094,     0,    a_a, 1, 0,    1, 0);
    add_row(KEEP_CFG, 0,    a_b, 1, 4094, 1, 0);
    add_row(KEEP_CFG, 0,    a_c, 1, 4095, 1, 0);
    add_row(KEEP_CFG, 0,    a_d, 1, 0,    0, 1);
    add_row(KEEP_CFG, 4093, a_d, 1, 4093, 1, 0);
    add_row(KEEP_CFG, 0,    a_b, 1, 4094, 0, 0);
    // Oversized count saturates; no room left to append.
    add_row(5000,     4095, ones, 1, 4095, 1, 0);
    add_row(KEEP_CFG, 4095, pz,   1, 0,    0, 1);

    foreach (rows[i]) begin
      if (rows[i].cfg != KEEP_CFG) begin
        corner.valid <= 1'b0;
        set_count(rows[i].cfg);
      end
      send_corner(rows[i].orig, rows[i].attr, rows[i].typed, rows[i].res);
    end

    // Random phases: position_count, sender idle %, receiver stall %.
    counts = '{1, 4, 16, 4096, 5000, 0, 7};
    idles  = '{0, 52, 0, 24, 0, 52, 24};
    stalls = '{0, 0, 52, 24, 0, 52, 0};
    for (int p = 0; p < 7; p++) begin
      corner.valid <= 1'b0;
      send_idle_pct = 0;
      set_count(counts[p]);
      send_idle_pct  = idles[p];
      recv_stall_pct = stalls[p];
      foreach (pool[k]) pool[k] = rand_attr();
      for (int n = 0; n < 145; n++) begin
        if (p == 1 && n == 40) begin
          hold_go = ~hold_go;        // long receiver hold-off, input fills up
        end
        if (p == 2 && n == 70) begin
          corner.valid <= 1'b0;      // drain completely before going on
          do @(posedge clk); while (pending_q.size() != 0);
        end
        if (pos_count > 0 && $urandom_range(99) < 88)
          orig = uvdt_pkg::IDX_W'($urandom_range(pos_count - 1));
        else
          orig = uvdt_pkg::IDX_W'($urandom);
        a = ($urandom_range(99) < 70) ? pool[$urandom_range(5)] : rand_attr();
        send_corner(orig, a, 1'b0, '0);
      end
    end

    corner.valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
